@@ rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Field widths, command and status codes, and the control and status
// structs that join the heap controller to the heap datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // Field widths of the command and result transactions.
    localparam int CMD_W        = 3;
    localparam int KEY_W        = 32;
    localparam int SLOT_W       = 6;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 7;

    // Default number of keys the heap holds.
    localparam int DEF_CAPACITY = 64;

    // Most negative key; delete lowers the doomed entry to this value.
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    // Command codes; the codes above peek are ignored.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_EXTRACT  = 3'd1,
        CMD_DECREASE = 3'd2,
        CMD_DELETE   = 3'd3,
        CMD_PEEK     = 3'd4
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_FULL        = 3'd2,
        ST_RANGE       = 3'd3,
        ST_NOT_SMALLER = 3'd4
    } status_t;

    // Address pair presented to the two key store read ports.
    typedef enum logic [2:0] {
        RD_NONE     = 3'd0,
        RD_SLOT     = 3'd1,
        RD_ROOT     = 3'd2,
        RD_PARENT   = 3'd3,
        RD_CHILDREN = 3'd4
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        rd_sel_t rd;
        logic    set_status;
        status_t status_code;
        logic    take_value;
        logic    start_up;
        logic    up_at_end;
        logic    up_min;
        logic    remove;
        logic    wr_key;
        logic    up_move;
        logic    dn_move;
        logic    publish;
    } dp_ctl_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic last_one;
        logic out_of_range;
        logic not_smaller;
        logic at_root;
        logic up_stop;
        logic dn_stop;
        logic res_free;
    } dp_sts_t;

endpackage

@@ rtl/mhpq_if.sv @@
// ----------------------------------------------------------------------------
// Min-heap priority queue channel interfaces
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------

// Command channel: one heap operation per transaction.
interface mhpq_cmd_if;
    logic                                valid;
    logic                                ready;
    logic        [mhpq_pkg::CMD_W-1:0]   command;
    logic signed [mhpq_pkg::KEY_W-1:0]   key;
    logic        [mhpq_pkg::SLOT_W-1:0]  slot;

    modport source (output valid, output command, output key, output slot, input ready);
    modport sink   (input valid, input command, input key, input slot, output ready);
endinterface

// Result channel: one result per command.
interface mhpq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mhpq_pkg::KEY_W-1:0]    value;
    logic        [mhpq_pkg::STATUS_W-1:0] status;
    logic        [mhpq_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output value, output status, output count, input ready);
    modport sink   (input valid, input value, input status, input count, output ready);
endinterface

@@ rtl/mhpq_datapath.sv @@
// ----------------------------------------------------------------------------
// Min-heap priority queue datapath
// Key store with one write and two registered read ports, the entry count,
// the moving key and hole index of a sift, and the result register.
// ----------------------------------------------------------------------------
module mhpq_datapath #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mhpq_pkg::dp_ctl_t                    ctl,
    output mhpq_pkg::dp_sts_t                    sts,
    input  logic signed [mhpq_pkg::KEY_W-1:0]    in_key,
    input  logic        [mhpq_pkg::SLOT_W-1:0]   in_slot,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic signed [mhpq_pkg::KEY_W-1:0]    res_value,
    output logic        [mhpq_pkg::STATUS_W-1:0] res_status,
    output logic        [mhpq_pkg::COUNT_W-1:0]  res_count
);

    localparam int KW    = mhpq_pkg::KEY_W;
    localparam int SLW   = mhpq_pkg::SLOT_W;
    localparam int CNT_W = mhpq_pkg::COUNT_W;
    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int XW    = IW + 2;
    localparam int SW    = (CW > SLW) ? CW : SLW;

    // Key store.
    logic signed [KW-1:0] mem [CAPACITY];

    logic        [CW-1:0]  count_reg, count_next;
    logic                  res_valid_reg, res_valid_next;
    logic        [IW-1:0]  hole_reg, hole_next;
    logic signed [KW-1:0]  mkey_reg, mkey_next;
    logic signed [KW-1:0]  value_reg, value_next;
    mhpq_pkg::status_t     status_reg, status_next;
    logic signed [KW-1:0]  key_reg;
    logic        [SLW-1:0] slot_reg;
    logic signed [KW-1:0]  rd_a_reg, rd_b_reg;
    logic signed [KW-1:0]  res_value_reg;
    mhpq_pkg::status_t     res_status_reg;
    logic        [CNT_W-1:0] res_count_reg;

    logic        [IW-1:0]  parent;
    logic        [XW-1:0]  lch, rch, count_x;
    logic                  l_valid, r_valid, l_ok, r_ok;
    logic signed [KW-1:0]  best, dn_val;
    logic        [IW-1:0]  dn_idx, last, ra, rb, waddr;
    logic                  rd_en, we;
    logic signed [KW-1:0]  wdata;

    // Tree neighbors of the hole.
    assign parent  = (hole_reg - IW'(1)) >> 1;
    assign lch     = {1'b0, hole_reg, 1'b1};
    assign rch     = lch + XW'(1);
    assign count_x = XW'(count_reg);
    assign l_valid = lch < count_x;
    assign r_valid = rch < count_x;
    assign last    = IW'(count_reg - CW'(1));

    // Smaller child of the hole, if either child is below the moving key.
    assign l_ok   = l_valid && (rd_a_reg < mkey_reg);
    assign best   = l_ok ? rd_a_reg : mkey_reg;
    assign r_ok   = r_valid && (rd_b_reg < best);
    assign dn_val = r_ok ? rd_b_reg : rd_a_reg;
    assign dn_idx = r_ok ? IW'(rch) : IW'(lch);

    // Read address selection.
    always_comb
    begin
        unique case (ctl.rd)
            mhpq_pkg::RD_SLOT:
            begin
                ra = IW'(slot_reg);
                rb = last;
            end
            mhpq_pkg::RD_ROOT:
            begin
                ra = '0;
                rb = last;
            end
            mhpq_pkg::RD_PARENT:
            begin
                ra = parent;
                rb = parent;
            end
            mhpq_pkg::RD_CHILDREN:
            begin
                ra = IW'(lch);
                rb = IW'(rch);
            end
            default:
            begin
                ra = '0;
                rb = '0;
            end
        endcase
    end
    assign rd_en = ctl.rd != mhpq_pkg::RD_NONE;

    // Write port: the moving key settles, or an entry moves into the hole.
    assign we    = ctl.wr_key || ctl.up_move || ctl.dn_move;
    assign waddr = hole_reg;
    always_comb
    begin
        priority if (ctl.wr_key)
            wdata = mkey_reg;
        else if (ctl.up_move)
            wdata = rd_a_reg;
        else
            wdata = dn_val;
    end

    // Key store ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[ra];
            rd_b_reg <= mem[rb];
        end
    end

    // Next values of the sift and result state.
    always_comb
    begin
        count_next     = count_reg;
        hole_next      = hole_reg;
        mkey_next      = mkey_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg;

        if (ctl.load)
        begin
            value_next  = '0;
            status_next = mhpq_pkg::ST_OK;
        end
        if (ctl.set_status)
        begin
            status_next = ctl.status_code;
        end
        if (ctl.take_value)
        begin
            value_next = rd_a_reg;
        end
        if (ctl.start_up)
        begin
            if (ctl.up_at_end)
            begin
                hole_next  = IW'(count_reg);
                count_next = count_reg + CW'(1);
            end
            else
            begin
                hole_next = IW'(slot_reg);
            end
            mkey_next = ctl.up_min ? mhpq_pkg::KEY_MIN : key_reg;
        end
        if (ctl.remove)
        begin
            count_next = count_reg - CW'(1);
            mkey_next  = rd_b_reg;
            hole_next  = '0;
        end
        if (ctl.up_move)
        begin
            hole_next = parent;
        end
        if (ctl.dn_move)
        begin
            hole_next = dn_idx;
        end
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (ctl.publish)
        begin
            res_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hole_reg   <= hole_next;
        mkey_reg   <= mkey_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        if (ctl.load)
        begin
            key_reg  <= in_key;
            slot_reg <= in_slot;
        end
        if (ctl.publish)
        begin
            res_value_reg  <= value_reg;
            res_status_reg <= status_reg;
            res_count_reg  <= CNT_W'(count_reg);
        end
    end

    // Status flags for the controller.
    assign sts.full         = count_reg == CW'(CAPACITY);
    assign sts.empty        = count_reg == '0;
    assign sts.last_one     = count_reg == CW'(1);
    assign sts.out_of_range = SW'(slot_reg) >= SW'(count_reg);
    assign sts.not_smaller  = key_reg > rd_a_reg;
    assign sts.at_root      = hole_reg == '0;
    assign sts.up_stop      = rd_a_reg <= mkey_reg;
    assign sts.dn_stop      = !l_ok && !r_ok;
    assign sts.res_free     = !res_valid_reg || res_ready;

    assign res_valid  = res_valid_reg;
    assign res_value  = res_value_reg;
    assign res_status = res_status_reg;
    assign res_count  = res_count_reg;

    // Every store write lands inside the live part of the heap.
    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (CW'(hole_reg) < count_reg))
        else $error("key store write outside the live heap");

    // A sift-up step never moves above the root.
    a_up_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.up_move |-> (hole_reg != '0))
        else $error("sift-up step taken at the root");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.publish |-> (!res_valid_reg || res_ready))
        else $error("result register overwritten while pending");

    // The entry count stays within capacity and removal needs an entry.
    a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CW'(CAPACITY)) && (!ctl.remove || (count_reg != '0)))
        else $error("entry count out of bounds");

endmodule

@@ rtl/mhpq_controller.sv @@
// ----------------------------------------------------------------------------
// Min-heap priority queue controller
// State machine that sequences the checks, sift-up and sift-down steps of
// each command and hands the result to the output register.
// ----------------------------------------------------------------------------
module mhpq_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mhpq_pkg::CMD_W-1:0]        in_command,
    output mhpq_pkg::dp_ctl_t                 ctl,
    input  mhpq_pkg::dp_sts_t                 sts
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_LOOK    = 10'b00_0000_0010,
        S_CHECK   = 10'b00_0000_0100,
        S_UP_RD   = 10'b00_0000_1000,
        S_UP_CMP  = 10'b00_0001_0000,
        S_DEL_RD  = 10'b00_0010_0000,
        S_DEL_CMP = 10'b00_0100_0000,
        S_DN_RD   = 10'b00_1000_0000,
        S_DN_CMP  = 10'b01_0000_0000,
        S_FIN     = 10'b10_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [mhpq_pkg::CMD_W-1:0] cmd_reg;
    logic                       is_delete;
    state_t                     after_up;

    assign in_ready  = state_reg == S_IDLE;
    assign is_delete = cmd_reg == mhpq_pkg::CMD_DELETE;
    assign after_up  = is_delete ? S_DEL_RD : S_FIN;

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        ctl             = '0;
        ctl.rd          = mhpq_pkg::RD_NONE;
        ctl.status_code = mhpq_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (cmd_reg == mhpq_pkg::CMD_DECREASE)
                    ctl.rd = mhpq_pkg::RD_SLOT;
                else
                    ctl.rd = mhpq_pkg::RD_ROOT;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_FIN;
                unique case (mhpq_pkg::cmd_t'(cmd_reg))
                    mhpq_pkg::CMD_INSERT:
                    begin
                        if (sts.full)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = mhpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.start_up  = 1'b1;
                            ctl.up_at_end = 1'b1;
                            state_next    = S_UP_RD;
                        end
                    end
                    mhpq_pkg::CMD_EXTRACT:
                    begin
                        if (sts.empty)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = mhpq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctl.take_value = 1'b1;
                            ctl.remove     = 1'b1;
                            if (!sts.last_one)
                                state_next = S_DN_RD;
                        end
                    end
                    mhpq_pkg::CMD_DECREASE:
                    begin
                        if (sts.out_of_range)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = mhpq_pkg::ST_RANGE;
                        end
                        else if (sts.not_smaller)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = mhpq_pkg::ST_NOT_SMALLER;
                        end
                        else
                        begin
                            ctl.start_up = 1'b1;
                            state_next   = S_UP_RD;
                        end
                    end
                    mhpq_pkg::CMD_DELETE:
                    begin
                        if (sts.out_of_range)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = mhpq_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ctl.start_up = 1'b1;
                            ctl.up_min   = 1'b1;
                            state_next   = S_UP_RD;
                        end
                    end
                    mhpq_pkg::CMD_PEEK:
                    begin
                        if (sts.empty)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = mhpq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctl.take_value = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Unused command codes leave the heap alone.
                    end
                endcase
            end
            S_UP_RD:
            begin
                if (sts.at_root)
                begin
                    ctl.wr_key = 1'b1;
                    state_next = after_up;
                end
                else
                begin
                    ctl.rd     = mhpq_pkg::RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.up_stop)
                begin
                    ctl.wr_key = 1'b1;
                    state_next = after_up;
                end
                else
                begin
                    ctl.up_move = 1'b1;
                    state_next  = S_UP_RD;
                end
            end
            S_DEL_RD:
            begin
                ctl.rd     = mhpq_pkg::RD_ROOT;
                state_next = S_DEL_CMP;
            end
            S_DEL_CMP:
            begin
                ctl.remove = 1'b1;
                state_next = sts.last_one ? S_FIN : S_DN_RD;
            end
            S_DN_RD:
            begin
                ctl.rd     = mhpq_pkg::RD_CHILDREN;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (sts.dn_stop)
                begin
                    ctl.wr_key = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.dn_move = 1'b1;
                    state_next  = S_DN_RD;
                end
            end
            S_FIN:
            begin
                if (sts.res_free)
                begin
                    ctl.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command code of the transaction in progress.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_command;
        end
    end

endmodule

@@ rtl/min_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Min-heap priority queue
// Binary min-heap of signed keys with insert, extract-minimum, decrease-key,
// delete-at-slot and peek commands, one result per command.
//
//   channel  modport  payload                 transfers on
//   cmd      sink     command, key, slot      valid && ready
//   res      source   value, status, count    valid && ready
//
// A command runs through load, read and check states; sift-up then repeats a
// parent read and a compare for each level moved, sift-down a children read
// and a compare for each level, and delete runs sift-up, then a root read and
// the removal, then sift-down, before the result is published.
// The next command is taken while a result waits in the output register; only
// its own result stalls. Reset clears the entry count, not the key store.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input logic     clk,
    input logic     rst_n,
    mhpq_cmd_if.sink   cmd,
    mhpq_rsp_if.source res
);

    mhpq_pkg::dp_ctl_t ctl;
    mhpq_pkg::dp_sts_t sts;
    logic              cmd_ready;

    // Sequencing of each command.
    mhpq_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_ready   (cmd_ready),
        .in_command (cmd.command),
        .ctl        (ctl),
        .sts        (sts)
    );

    // Key store, sift registers and result register.
    mhpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_key     (cmd.key),
        .in_slot    (cmd.slot),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .res_value  (res.value),
        .res_status (res.status),
        .res_count  (res.count)
    );

    assign cmd.ready = cmd_ready;

endmodule

@@ tb/tb_min_heap_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue testbench
// Drives command transactions into the heap and checks every result against
// a software copy of the heap kept in the testbench. Directed tests cover the
// empty heap, each command and a full heap; random traffic then fills and
// drains the heap repeatedly under random idling and a long result stall.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue;

    import mhpq_pkg::*;

    // Test setup.
    localparam int HEAP_DEPTH    = DEF_CAPACITY;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 37;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 4000;
    localparam int END_SETTLE    = 64;
    localparam int RAND_PHASES   = 7;
    localparam int PHASE_ITEMS   = 150;
    localparam int CALM_PHASE    = 3;
    localparam logic [SLOT_W-1:0] SLOT_LAST = '1;

    // Command codes above peek do nothing.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(CMD_PEEK + 1);
    localparam logic [CMD_W-1:0] CMD_CODE_LAST   = '1;

    // Largest key.
    localparam logic signed [KEY_W-1:0] KEY_TOP = ~KEY_MIN;

    // One predicted result.
    typedef struct {
        logic signed [KEY_W-1:0]   value;
        status_t                   status;
        logic        [COUNT_W-1:0] count;
    } heap_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    mhpq_cmd_if cmd_ch ();
    mhpq_rsp_if res_ch ();

    // Shadow heap that tracks what the block should hold.
    logic signed [KEY_W-1:0] model_keys [HEAP_DEPTH];
    int unsigned             model_count = 0;
    heap_reply_t             owed_replies [$];

    // Run bookkeeping.
    int  mismatch_count = 0;
    int  results_checked = 0;
    int  full_seen = 0;
    int  empty_seen = 0;
    int  cmd_tally [1 << CMD_W];
    bit  sender_gaps_on = 1'b1;
    bit  rx_gaps_on = 1'b1;
    bit  growing = 1'b1;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    min_heap_priority_queue #(
        .CAPACITY (HEAP_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Moves the entry at a slot toward the root while its parent is larger.
    function automatic void heap_sift_up(int unsigned s);
        int unsigned             p;
        logic signed [KEY_W-1:0] t;
        while (s > 0)
        begin
            p = (s - 1) / 2;
            if (model_keys[p] <= model_keys[s])
                break;
            t = model_keys[p];
            model_keys[p] = model_keys[s];
            model_keys[s] = t;
            s = p;
        end
    endfunction

    // Moves the entry at a slot toward the leaves while a child is smaller.
    function automatic void heap_sift_down(int unsigned s);
        int unsigned             l;
        int unsigned             r;
        int unsigned             m;
        logic signed [KEY_W-1:0] t;
        forever
        begin
            l = 2 * s + 1;
            r = l + 1;
            m = s;
            if (l < model_count && model_keys[l] < model_keys[m])
                m = l;
            if (r < model_count && model_keys[r] < model_keys[m])
                m = r;
            if (m == s)
                break;
            t = model_keys[m];
            model_keys[m] = model_keys[s];
            model_keys[s] = t;
            s = m;
        end
    endfunction

    // Removes the root and refills it from the last entry.
    function automatic logic signed [KEY_W-1:0] heap_pop_root();
        logic signed [KEY_W-1:0] top;
        top = model_keys[0];
        model_count--;
        if (model_count > 0)
        begin
            model_keys[0] = model_keys[model_count];
            heap_sift_down(0);
        end
        return top;
    endfunction

    // Applies one command to the shadow heap and returns the result it owes.
    function automatic heap_reply_t heap_apply(logic [CMD_W-1:0] code,
                                               logic signed [KEY_W-1:0] key_in,
                                               logic [SLOT_W-1:0] slot_in);
        heap_reply_t r;
        r.value  = '0;
        r.status = ST_OK;
        case (code)
            CMD_INSERT:
                if (model_count >= HEAP_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    model_keys[model_count] = key_in;
                    model_count++;
                    heap_sift_up(model_count - 1);
                end
            CMD_EXTRACT:
                if (model_count == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = heap_pop_root();
            CMD_DECREASE:
                if (slot_in >= model_count)
                    r.status = ST_RANGE;
                else if (key_in > model_keys[slot_in])
                    r.status = ST_NOT_SMALLER;
                else
                begin
                    model_keys[slot_in] = key_in;
                    heap_sift_up(slot_in);
                end
            CMD_DELETE:
                if (slot_in >= model_count)
                    r.status = ST_RANGE;
                else
                begin
                    model_keys[slot_in] = KEY_MIN;
                    heap_sift_up(slot_in);
                    void'(heap_pop_root());
                end
            CMD_PEEK:
                if (model_count == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = model_keys[0];
            default:
                ;
        endcase
        if (r.status == ST_FULL)
            full_seen++;
        if (r.status == ST_EMPTY)
            empty_seen++;
        r.count = model_count[COUNT_W-1:0];
        return r;
    endfunction

    // Key mix: extremes, a narrow band that makes duplicates, and full range.
    function automatic logic signed [KEY_W-1:0] rand_key();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return KEY_MIN;
        if (pick < 20)
            return KEY_TOP;
        if (pick < 50)
            return $signed($urandom_range(32)) - 16;
        return $urandom;
    endfunction

    // Mostly slots inside the heap, sometimes slots beyond its end.
    function automatic logic [SLOT_W-1:0] pick_slot();
        if (model_count > 0 && $urandom_range(99) < 85)
            return SLOT_W'($urandom_range(model_count - 1));
        if (model_count <= SLOT_LAST)
            return SLOT_W'($urandom_range(SLOT_LAST, model_count));
        return SLOT_W'($urandom_range(SLOT_LAST));
    endfunction

    // New key for decrease-key: usually smaller or equal, sometimes larger.
    function automatic logic signed [KEY_W-1:0] decrease_key(logic [SLOT_W-1:0] slot_in);
        longint      v;
        int unsigned pick;
        if (slot_in >= model_count)
            return rand_key();
        v = longint'(model_keys[slot_in]);
        pick = $urandom_range(99);
        if (pick < 15)
            ;
        else if (pick < 65)
            v = v - $urandom_range(1000, 1);
        else if (pick < 80)
            v = longint'(rand_key());
        else
            v = v + $urandom_range(1000, 1);
        if (v < longint'(KEY_MIN))
            v = longint'(KEY_MIN);
        if (v > longint'(KEY_TOP))
            v = longint'(KEY_TOP);
        return v[KEY_W-1:0];
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one command, waits for its transaction and records its result.
    task automatic send_cmd(input logic [CMD_W-1:0] code,
                            input logic signed [KEY_W-1:0] key_in,
                            input logic [SLOT_W-1:0] slot_in);
        if (sender_gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= code;
        cmd_ch.key     <= key_in;
        cmd_ch.slot    <= slot_in;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        owed_replies.push_back(heap_apply(code, key_in, slot_in));
        cmd_tally[code]++;
    endtask

    // Stops offering and waits until every owed result has arrived.
    task automatic wait_for_replies();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_replies.size() != 0);
    endtask

    // Picks a command weighted toward growing or shrinking the heap.
    task automatic send_random_cmd(input bit fill);
        int unsigned             pick;
        logic [CMD_W-1:0]        code;
        logic [SLOT_W-1:0]       slot_v;
        logic signed [KEY_W-1:0] key_v;
        pick = $urandom_range(99);
        if (pick < (fill ? 50 : 20))
            code = CMD_INSERT;
        else if (pick < (fill ? 62 : 50))
            code = CMD_EXTRACT;
        else if (pick < (fill ? 77 : 68))
            code = CMD_DECREASE;
        else if (pick < (fill ? 87 : 83))
            code = CMD_DELETE;
        else if (pick < 96)
            code = CMD_PEEK;
        else
            code = CMD_W'($urandom_range(CMD_CODE_LAST, CMD_SPARE_FIRST));
        slot_v = pick_slot();
        key_v  = (code == CMD_DECREASE) ? decrease_key(slot_v) : rand_key();
        send_cmd(code, key_v, slot_v);
    endtask

    // Commands on an empty heap, including the unused codes.
    task automatic test_empty_heap();
        send_cmd(CMD_EXTRACT, KEY_TOP, SLOT_LAST);
        send_cmd(CMD_PEEK, KEY_MIN, '0);
        send_cmd(CMD_DECREASE, KEY_MIN, '0);
        send_cmd(CMD_DELETE, KEY_TOP, SLOT_LAST);
        for (int c = CMD_SPARE_FIRST; c <= CMD_CODE_LAST; c++)
            send_cmd(CMD_W'(c), (c % 2) ? KEY_MIN : KEY_TOP, (c % 2) ? SLOT_LAST : '0);
        wait_for_replies();
    endtask

    // Each command on a small heap, with key extremes and duplicates.
    task automatic test_basic_ops();
        send_cmd(CMD_INSERT, KEY_TOP, '0);
        send_cmd(CMD_INSERT, KEY_MIN, SLOT_LAST);
        send_cmd(CMD_INSERT, 0, '0);
        send_cmd(CMD_INSERT, -1, '0);
        send_cmd(CMD_INSERT, 5, '0);
        send_cmd(CMD_INSERT, 5, '0);
        send_cmd(CMD_PEEK, KEY_TOP, '0);
        // Equal key is accepted, larger key is refused.
        send_cmd(CMD_DECREASE, model_keys[3], SLOT_W'(3));
        send_cmd(CMD_DECREASE, model_keys[4] + 1, SLOT_W'(4));
        // Lowering to the most negative key ties with the root.
        send_cmd(CMD_DECREASE, KEY_MIN, SLOT_W'(5));
        send_cmd(CMD_DECREASE, KEY_MIN, SLOT_W'(6));
        send_cmd(CMD_DELETE, KEY_TOP, SLOT_W'(3));
        send_cmd(CMD_DELETE, KEY_TOP, '0);
        send_cmd(CMD_DELETE, KEY_TOP, SLOT_W'(model_count - 1));
        send_cmd(CMD_DELETE, KEY_TOP, SLOT_LAST);
        send_cmd(CMD_PEEK, '0, '0);
        repeat (4)
            send_cmd(CMD_EXTRACT, KEY_MIN, SLOT_LAST);
        wait_for_replies();
    endtask

    // Fill to capacity, insert into the full heap, peek, decrease and delete at the last slot, then drain to empty.
    task automatic test_capacity();
        repeat (HEAP_DEPTH)
            send_cmd(CMD_INSERT, rand_key(), SLOT_W'($urandom_range(SLOT_LAST)));
        repeat (2)
            send_cmd(CMD_INSERT, rand_key(), SLOT_W'($urandom_range(SLOT_LAST)));
        send_cmd(CMD_PEEK, rand_key(), SLOT_LAST);
        send_cmd(CMD_DECREASE, decrease_key(SLOT_LAST), SLOT_LAST);
        send_cmd(CMD_DELETE, rand_key(), SLOT_LAST);
        repeat (2)
            send_cmd(CMD_INSERT, rand_key(), SLOT_W'($urandom_range(SLOT_LAST)));
        repeat (HEAP_DEPTH + 1)
            send_cmd(CMD_EXTRACT, rand_key(), SLOT_W'($urandom_range(SLOT_LAST)));
        wait_for_replies();
    endtask

    // Result side holds off for a long stretch while commands keep coming.
    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        hold_requests <= hold_requests + 1;
        repeat (24)
            send_random_cmd(1'b1);
        wait_for_replies();
        sender_gaps_on = 1'b1;
    endtask

    // Random phases that fill and drain the heap; one phase has no idling.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            bit calm;
            calm = (phase == CALM_PHASE);
            sender_gaps_on = !calm;
            rx_gaps_on <= !calm;
            repeat (PHASE_ITEMS)
            begin
                if (model_count >= HEAP_DEPTH && $urandom_range(3) == 0)
                    growing = 1'b0;
                else if (model_count == 0)
                    growing = 1'b1;
                send_random_cmd(growing);
            end
            wait_for_replies();
        end
        sender_gaps_on = 1'b1;
        rx_gaps_on <= 1'b1;
    endtask

    // Result side ready: random idling, plus long holds on request.
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_served + 1;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (!rx_gaps_on)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each result transaction with the oldest owed result.
    always @(posedge clk)
    begin
        heap_reply_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (owed_replies.size() == 0)
                flag_mismatch($sformatf("result with none owed: value %0d status %0d count %0d",
                                        res_ch.value, res_ch.status, res_ch.count));
            else
            begin
                want = owed_replies.pop_front();
                results_checked++;
                if (res_ch.value !== want.value)
                    flag_mismatch($sformatf("value got %0d want %0d",
                                            res_ch.value, want.value));
                if (res_ch.status !== want.status)
                    flag_mismatch($sformatf("status got %0d want %0d",
                                            res_ch.status, want.status));
                if (res_ch.count !== want.count)
                    flag_mismatch($sformatf("count got %0d want %0d",
                                            res_ch.count, want.count));
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] Watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        int spare_total;
        spare_total = 0;
        foreach (cmd_tally[i])
            cmd_tally[i] = 0;
        rst_n = 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_PEEK;
        cmd_ch.key     <= '0;
        cmd_ch.slot    <= '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        test_empty_heap();
        test_basic_ops();
        test_capacity();
        test_backpressure();
        test_random_traffic();

        // Let any stray result show up before the final verdict.
        repeat (END_SETTLE)
            @(posedge clk);
        if (owed_replies.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", owed_replies.size()));

        for (int c = CMD_SPARE_FIRST; c <= CMD_CODE_LAST; c++)
            spare_total += cmd_tally[c];
        $display("Sent %0d insert, %0d extract, %0d decrease, %0d delete, %0d peek, %0d unused",
                 cmd_tally[CMD_INSERT], cmd_tally[CMD_EXTRACT], cmd_tally[CMD_DECREASE],
                 cmd_tally[CMD_DELETE], cmd_tally[CMD_PEEK], spare_total);
        $display("Checked %0d results; full-heap refusals %0d, empty-heap results %0d",
                 results_checked, full_seen, empty_seen);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
